### rtl/core/resource_barrier_tracker_assert.svh
// Assertion macros for the resource barrier tracker.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef RESOURCE_BARRIER_TRACKER_ASSERT_SVH
`define RESOURCE_BARRIER_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever cond holds, prop holds too.
`define RBT_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication: whenever cond holds, prop must hold in the cycle after.
`define RBT_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define RBT_ASSERT_IMPLY(label, cond, prop, msg)
`define RBT_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

### rtl/core/rbt_pkg.sv
// Shared types and constants for the resource barrier tracker.
// No dependencies; the RTL files other than the assertion header name it by scope, and the bench imports it.
package rbt_pkg;

    localparam int NUM_RESOURCES = 256;
    localparam int RES_IDX_W     = $clog2(NUM_RESOURCES);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W     = 8;
    localparam int MASK_W   = 17;
    localparam int LAYOUT_W = 4;
    localparam int ASPECT_W = 3;
    localparam int LEVEL_W  = 5;
    localparam int LAYER_W  = 12;

    // Operation codes
    localparam logic [1:0] OP_USE     = 2'd0;
    localparam logic [1:0] OP_PRESENT = 2'd1;
    localparam logic [1:0] OP_FRAME   = 2'd2;

    // Usage codes
    localparam logic [2:0] USG_COLOR   = 3'd0;
    localparam logic [2:0] USG_RESOLVE = 3'd1;
    localparam logic [2:0] USG_DS      = 3'd2;
    localparam logic [2:0] USG_COPY    = 3'd3;
    localparam logic [2:0] USG_SHADER  = 3'd4;
    localparam logic [2:0] USG_SUBPASS = 3'd5;

    // Pass and format kinds
    localparam logic [1:0] PK_COMPUTE  = 2'd0;
    localparam logic [1:0] PK_GRAPHICS = 2'd1;
    localparam logic [1:0] FK_DEPTH    = 2'd1;
    localparam logic [1:0] FK_DS       = 2'd2;

    // Barrier kinds
    localparam logic [1:0] BK_IMAGE_PRE    = 2'd0;
    localparam logic [1:0] BK_BUFFER_PRE   = 2'd1;
    localparam logic [1:0] BK_PRESENT_POST = 2'd2;

    // Pipeline stage bits
    localparam logic [MASK_W-1:0] STG_NONE      = 17'h00000;
    localparam logic [MASK_W-1:0] STG_FRAG      = 17'h00080;
    localparam logic [MASK_W-1:0] STG_EARLY_FT  = 17'h00100;
    localparam logic [MASK_W-1:0] STG_LATE_FT   = 17'h00200;
    localparam logic [MASK_W-1:0] STG_COLOR_OUT = 17'h00400;
    localparam logic [MASK_W-1:0] STG_COMPUTE   = 17'h00800;
    localparam logic [MASK_W-1:0] STG_TRANSFER  = 17'h01000;
    localparam logic [MASK_W-1:0] STG_ALL_GFX   = 17'h08000;
    localparam logic [MASK_W-1:0] STG_ALL_CMD   = 17'h10000;

    // Access bits
    localparam logic [MASK_W-1:0] ACC_NONE      = 17'h00000;
    localparam logic [MASK_W-1:0] ACC_INPUT_RD  = 17'h00010;
    localparam logic [MASK_W-1:0] ACC_SHADER_RD = 17'h00020;
    localparam logic [MASK_W-1:0] ACC_SHADER_WR = 17'h00040;
    localparam logic [MASK_W-1:0] ACC_COLOR_RD  = 17'h00080;
    localparam logic [MASK_W-1:0] ACC_COLOR_WR  = 17'h00100;
    localparam logic [MASK_W-1:0] ACC_DS_RD     = 17'h00200;
    localparam logic [MASK_W-1:0] ACC_DS_WR     = 17'h00400;
    localparam logic [MASK_W-1:0] ACC_XFER_RD   = 17'h00800;
    localparam logic [MASK_W-1:0] ACC_XFER_WR   = 17'h01000;
    localparam logic [MASK_W-1:0] ACC_MEM_RD    = 17'h08000;
    localparam logic [MASK_W-1:0] ACC_MEM_WR    = 17'h10000;
    localparam logic [MASK_W-1:0] ACC_ANY_WRITE =
        ACC_MEM_WR | ACC_SHADER_WR | ACC_COLOR_WR | ACC_DS_WR | ACC_XFER_WR;

    // Image layouts
    localparam logic [LAYOUT_W-1:0] LAY_UNDEF     = 4'd0;
    localparam logic [LAYOUT_W-1:0] LAY_GENERAL   = 4'd1;
    localparam logic [LAYOUT_W-1:0] LAY_COLOR     = 4'd2;
    localparam logic [LAYOUT_W-1:0] LAY_DS        = 4'd3;
    localparam logic [LAYOUT_W-1:0] LAY_DS_RO     = 4'd4;
    localparam logic [LAYOUT_W-1:0] LAY_SHADER_RO = 4'd5;
    localparam logic [LAYOUT_W-1:0] LAY_XFER_SRC  = 4'd6;
    localparam logic [LAYOUT_W-1:0] LAY_XFER_DST  = 4'd7;
    localparam logic [LAYOUT_W-1:0] LAY_PRESENT   = 4'd8;

    // Aspect bits
    localparam logic [ASPECT_W-1:0] ASP_COLOR   = 3'd1;
    localparam logic [ASPECT_W-1:0] ASP_DEPTH   = 3'd2;
    localparam logic [ASPECT_W-1:0] ASP_DEPTH_S = 3'd6;

    typedef enum logic [1:0] {
        CMD_USE,
        CMD_PRESENT,
        CMD_CLEAR
    } cmd_t;

    typedef enum logic {
        BACK_READ,
        BACK_EXEC
    } back_state_t;

    // Classified item passed from front to back
    typedef struct packed {
        cmd_t                cmd;
        logic [ID_W-1:0]     resource_id;
        logic                is_image;
        logic                is_swapchain;
        logic [MASK_W-1:0]   req_stages;
        logic [MASK_W-1:0]   req_access;
        logic [LAYOUT_W-1:0] req_layout;
        logic [ASPECT_W-1:0] aspect_mask;
        logic [LEVEL_W-1:0]  level_count;
        logic [LAYER_W-1:0]  layer_count;
    } q_item_t;

    // Per-resource tracked state
    typedef struct packed {
        logic [MASK_W-1:0]   stages;
        logic [MASK_W-1:0]   access;
        logic [LAYOUT_W-1:0] layout;
    } entry_t;

    // One barrier
    typedef struct packed {
        logic [ID_W-1:0]     resource_id_res;
        logic [1:0]          barrier_kind;
        logic                first_use;
        logic [MASK_W-1:0]   src_stages;
        logic [MASK_W-1:0]   src_access;
        logic [MASK_W-1:0]   dst_stages;
        logic [MASK_W-1:0]   dst_access;
        logic [LAYOUT_W-1:0] old_layout;
        logic [LAYOUT_W-1:0] new_layout;
        logic [ASPECT_W-1:0] aspect_mask;
        logic [LEVEL_W-1:0]  level_count;
        logic [LAYER_W-1:0]  layer_count;
    } res_t;

endpackage

### rtl/core/rbt_channels.sv
// Valid/ready channel interfaces for the resource barrier tracker.
// Depends on rbt_pkg for field widths.
interface rbt_use_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        op;
    logic [rbt_pkg::ID_W-1:0]          resource_id;
    logic                              is_image;
    logic                              is_swapchain;
    logic [2:0]                        usage;
    logic                              reads;
    logic                              writes;
    logic [1:0]                        pass_kind;
    logic [1:0]                        format_kind;
    logic [rbt_pkg::LEVEL_W-1:0]       mip_levels;
    logic [rbt_pkg::LAYER_W-1:0]       array_layers;

    modport source (
        output valid, op, resource_id, is_image, is_swapchain, usage, reads, writes,
               pass_kind, format_kind, mip_levels, array_layers,
        input  ready
    );
    modport sink (
        input  valid, op, resource_id, is_image, is_swapchain, usage, reads, writes,
               pass_kind, format_kind, mip_levels, array_layers,
        output ready
    );
endinterface

interface rbt_barrier_if;
    logic                              valid;
    logic                              ready;
    logic [rbt_pkg::ID_W-1:0]          resource_id_res;
    logic [1:0]                        barrier_kind;
    logic                              first_use;
    logic [rbt_pkg::MASK_W-1:0]        src_stages;
    logic [rbt_pkg::MASK_W-1:0]        src_access;
    logic [rbt_pkg::MASK_W-1:0]        dst_stages;
    logic [rbt_pkg::MASK_W-1:0]        dst_access;
    logic [rbt_pkg::LAYOUT_W-1:0]      old_layout;
    logic [rbt_pkg::LAYOUT_W-1:0]      new_layout;
    logic [rbt_pkg::ASPECT_W-1:0]      aspect_mask;
    logic [rbt_pkg::LEVEL_W-1:0]       level_count;
    logic [rbt_pkg::LAYER_W-1:0]       layer_count;

    modport source (
        output valid, resource_id_res, barrier_kind, first_use, src_stages, src_access,
               dst_stages, dst_access, old_layout, new_layout, aspect_mask,
               level_count, layer_count,
        input  ready
    );
    modport sink (
        input  valid, resource_id_res, barrier_kind, first_use, src_stages, src_access,
               dst_stages, dst_access, old_layout, new_layout, aspect_mask,
               level_count, layer_count,
        output ready
    );
endinterface

### rtl/core/rbt_front.sv
// Front end: accepts items and maps each use to its required state.
// Depends on rbt_pkg and rbt_channels; feeds rbt_queue.
module rbt_front (
    rbt_use_if.sink          use_ch,
    input  logic             q_ready,
    output logic             q_push,
    output rbt_pkg::q_item_t q_item
);

    logic                       in_table;
    logic                       keep;
    logic                       rd;
    logic                       wr;
    logic [rbt_pkg::MASK_W-1:0] shader_stg;

    assign use_ch.ready = q_ready;
    assign rd           = use_ch.reads;
    assign wr           = use_ch.writes;
    assign in_table     = (32'(use_ch.resource_id) < rbt_pkg::NUM_RESOURCES);

    always_comb
    begin
        case (use_ch.pass_kind)
            rbt_pkg::PK_COMPUTE:  shader_stg = rbt_pkg::STG_COMPUTE;
            rbt_pkg::PK_GRAPHICS: shader_stg = rbt_pkg::STG_ALL_GFX;
            default:              shader_stg = rbt_pkg::STG_ALL_CMD;
        endcase
    end

    always_comb
    begin
        q_item              = '0;
        q_item.cmd          = rbt_pkg::CMD_USE;
        q_item.resource_id  = use_ch.resource_id;
        q_item.is_image     = use_ch.is_image;
        q_item.is_swapchain = use_ch.is_swapchain;
        q_item.req_layout   = rbt_pkg::LAY_UNDEF;
        q_item.aspect_mask  = rbt_pkg::ASP_COLOR;
        q_item.level_count  = rbt_pkg::LEVEL_W'(1);
        q_item.layer_count  = rbt_pkg::LAYER_W'(1);
        keep                = 1'b0;

        if (use_ch.is_image)
        begin
            q_item.level_count = use_ch.mip_levels;
            q_item.layer_count = use_ch.array_layers;
            case (use_ch.format_kind)
                rbt_pkg::FK_DS:    q_item.aspect_mask = rbt_pkg::ASP_DEPTH_S;
                rbt_pkg::FK_DEPTH: q_item.aspect_mask = rbt_pkg::ASP_DEPTH;
                default:           q_item.aspect_mask = rbt_pkg::ASP_COLOR;
            endcase
        end

        unique case (use_ch.op)
            rbt_pkg::OP_FRAME:
            begin
                q_item.cmd = rbt_pkg::CMD_CLEAR;
                keep       = 1'b1;
            end
            rbt_pkg::OP_PRESENT:
            begin
                q_item.cmd = rbt_pkg::CMD_PRESENT;
                keep       = in_table && use_ch.is_swapchain;
            end
            rbt_pkg::OP_USE:
            begin
                if (use_ch.is_image)
                begin
                    unique case (use_ch.usage)
                        rbt_pkg::USG_COLOR, rbt_pkg::USG_RESOLVE:
                        begin
                            q_item.req_stages = rbt_pkg::STG_COLOR_OUT;
                            q_item.req_access = (rd ? rbt_pkg::ACC_COLOR_RD : rbt_pkg::ACC_NONE)
                                              | (wr ? rbt_pkg::ACC_COLOR_WR : rbt_pkg::ACC_NONE);
                            q_item.req_layout = rbt_pkg::LAY_COLOR;
                            keep              = in_table;
                        end
                        rbt_pkg::USG_DS:
                        begin
                            q_item.req_stages = rbt_pkg::STG_EARLY_FT | rbt_pkg::STG_LATE_FT;
                            q_item.req_access = (rd ? rbt_pkg::ACC_DS_RD : rbt_pkg::ACC_NONE)
                                              | (wr ? rbt_pkg::ACC_DS_WR : rbt_pkg::ACC_NONE);
                            q_item.req_layout = wr ? rbt_pkg::LAY_DS : rbt_pkg::LAY_DS_RO;
                            keep              = in_table;
                        end
                        rbt_pkg::USG_COPY:
                        begin
                            q_item.req_stages = rbt_pkg::STG_TRANSFER;
                            q_item.req_access = (rd ? rbt_pkg::ACC_XFER_RD : rbt_pkg::ACC_NONE)
                                              | (wr ? rbt_pkg::ACC_XFER_WR : rbt_pkg::ACC_NONE);
                            q_item.req_layout = (rd && wr) ? rbt_pkg::LAY_GENERAL
                                              : (rd ? rbt_pkg::LAY_XFER_SRC
                                                    : rbt_pkg::LAY_XFER_DST);
                            keep              = in_table;
                        end
                        rbt_pkg::USG_SHADER:
                        begin
                            q_item.req_stages = shader_stg;
                            q_item.req_access = (rd ? rbt_pkg::ACC_SHADER_RD : rbt_pkg::ACC_NONE)
                                              | (wr ? rbt_pkg::ACC_SHADER_WR : rbt_pkg::ACC_NONE);
                            q_item.req_layout = wr ? rbt_pkg::LAY_GENERAL
                                                   : rbt_pkg::LAY_SHADER_RO;
                            keep              = in_table;
                        end
                        rbt_pkg::USG_SUBPASS:
                        begin
                            q_item.req_stages = rbt_pkg::STG_FRAG;
                            q_item.req_access = rbt_pkg::ACC_INPUT_RD;
                            q_item.req_layout = rbt_pkg::LAY_SHADER_RO;
                            keep              = in_table;
                        end
                        default:
                        begin
                            keep = 1'b0;
                        end
                    endcase
                end
                else
                begin
                    unique case (use_ch.usage)
                        rbt_pkg::USG_COPY:
                        begin
                            q_item.req_stages = rbt_pkg::STG_TRANSFER;
                            q_item.req_access = (rd ? rbt_pkg::ACC_XFER_RD : rbt_pkg::ACC_NONE)
                                              | (wr ? rbt_pkg::ACC_XFER_WR : rbt_pkg::ACC_NONE);
                            keep              = in_table;
                        end
                        rbt_pkg::USG_SHADER:
                        begin
                            q_item.req_stages = shader_stg;
                            q_item.req_access = (rd ? rbt_pkg::ACC_SHADER_RD : rbt_pkg::ACC_NONE)
                                              | (wr ? rbt_pkg::ACC_SHADER_WR : rbt_pkg::ACC_NONE);
                            keep              = in_table;
                        end
                        default:
                        begin
                            keep = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Items with no effect are taken and dropped here
    assign q_push = use_ch.valid && q_ready && keep;

endmodule

### rtl/core/rbt_queue.sv
// Short FIFO of classified items between the front and back ends.
// Depends on rbt_pkg and the assertion macro header.
`include "resource_barrier_tracker_assert.svh"

module rbt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rbt_pkg::q_item_t push_item,
    output logic             ready,
    input  logic             pop,
    output logic             head_valid,
    output rbt_pkg::q_item_t head_item
);

    localparam logic [rbt_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        rbt_pkg::QUEUE_PTR_W'(rbt_pkg::QUEUE_DEPTH - 1);
    localparam logic [rbt_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
        rbt_pkg::QUEUE_CNT_W'(rbt_pkg::QUEUE_DEPTH);

    rbt_pkg::q_item_t                  slot_reg [rbt_pkg::QUEUE_DEPTH];
    logic [rbt_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [rbt_pkg::QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [rbt_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [rbt_pkg::QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [rbt_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [rbt_pkg::QUEUE_CNT_W-1:0]   count_next;

    assign ready      = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `RBT_ASSERT_IMPLY(a_q_no_overflow, push, count_reg != FULL_CNT, "push into full queue")
    `RBT_ASSERT_IMPLY(a_q_no_underflow, pop, count_reg != '0, "pop from empty queue")
    `RBT_ASSERT_NEXT(a_q_count_track, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost a push")

endmodule

### rtl/core/rbt_back.sv
// Back end: per-resource state table, barrier decision and output register.
// Depends on rbt_pkg, rbt_channels and the assertion macro header.
`include "resource_barrier_tracker_assert.svh"

module rbt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  rbt_pkg::q_item_t head_item,
    output logic             pop,
    rbt_barrier_if.source    barrier_ch
);

    rbt_pkg::back_state_t                state_reg;
    rbt_pkg::back_state_t                state_next;
    logic [rbt_pkg::NUM_RESOURCES-1:0]   known_reg;
    logic [rbt_pkg::NUM_RESOURCES-1:0]   known_next;
    rbt_pkg::entry_t                     state_mem [rbt_pkg::NUM_RESOURCES];
    rbt_pkg::entry_t                     rd_data_reg;
    rbt_pkg::res_t                       res_reg;
    rbt_pkg::res_t                       res_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;

    logic [rbt_pkg::RES_IDX_W-1:0]       idx;
    logic                                known;
    logic                                out_free;
    logic                                want_emit;
    logic                                want_write;
    logic                                go;
    logic                                any_write;
    rbt_pkg::entry_t                     prev;
    rbt_pkg::entry_t                     wr_entry;
    rbt_pkg::res_t                       res_cand;

    assign idx      = rbt_pkg::RES_IDX_W'(head_item.resource_id);
    assign known    = known_reg[idx];
    assign out_free = !out_valid_reg || barrier_ch.ready;

    // Previous state: table entry when known, else the first-use default
    always_comb
    begin
        if (known)
        begin
            prev = rd_data_reg;
        end
        else if (head_item.is_image && head_item.is_swapchain)
        begin
            prev = '{stages: rbt_pkg::STG_NONE, access: rbt_pkg::ACC_NONE,
                     layout: rbt_pkg::LAY_PRESENT};
        end
        else
        begin
            prev = '{stages: rbt_pkg::STG_ALL_CMD,
                     access: rbt_pkg::ACC_MEM_RD | rbt_pkg::ACC_MEM_WR,
                     layout: rbt_pkg::LAY_UNDEF};
        end
    end

    assign any_write = ((prev.access & rbt_pkg::ACC_ANY_WRITE) != '0)
                    || ((head_item.req_access & rbt_pkg::ACC_ANY_WRITE) != '0);

    always_comb
    begin
        want_emit  = 1'b0;
        want_write = 1'b0;
        wr_entry   = '{stages: head_item.req_stages, access: head_item.req_access,
                       layout: head_item.req_layout};
        res_cand   = '{resource_id_res: head_item.resource_id,
                       barrier_kind:    rbt_pkg::BK_IMAGE_PRE,
                       first_use:       !known,
                       src_stages:      prev.stages,
                       src_access:      prev.access,
                       dst_stages:      head_item.req_stages,
                       dst_access:      head_item.req_access,
                       old_layout:      prev.layout,
                       new_layout:      head_item.req_layout,
                       aspect_mask:     head_item.aspect_mask,
                       level_count:     head_item.level_count,
                       layer_count:     head_item.layer_count};

        case (head_item.cmd)
            rbt_pkg::CMD_USE:
            begin
                want_write = 1'b1;
                if (head_item.is_image)
                begin
                    want_emit = (prev.layout != head_item.req_layout) || any_write;
                end
                else
                begin
                    want_emit              = any_write;
                    res_cand.barrier_kind  = rbt_pkg::BK_BUFFER_PRE;
                    res_cand.first_use     = 1'b0;
                    res_cand.old_layout    = rbt_pkg::LAY_UNDEF;
                end
            end
            rbt_pkg::CMD_PRESENT:
            begin
                // Move to present unless already there; unknown entries are left alone
                want_write = known && (rd_data_reg.layout != rbt_pkg::LAY_PRESENT);
                want_emit  = want_write;
                wr_entry   = '{stages: rbt_pkg::STG_NONE, access: rbt_pkg::ACC_NONE,
                               layout: rbt_pkg::LAY_PRESENT};
                res_cand.barrier_kind = rbt_pkg::BK_PRESENT_POST;
                res_cand.first_use    = 1'b0;
                res_cand.dst_stages   = rbt_pkg::STG_NONE;
                res_cand.dst_access   = rbt_pkg::ACC_NONE;
                res_cand.new_layout   = rbt_pkg::LAY_PRESENT;
                res_cand.aspect_mask  = rbt_pkg::ASP_COLOR;
                res_cand.level_count  = rbt_pkg::LEVEL_W'(1);
                res_cand.layer_count  = rbt_pkg::LAYER_W'(1);
            end
            default:
            begin
                want_emit  = 1'b0;
                want_write = 1'b0;
            end
        endcase
    end

    // Sequencer: read the entry, then decide, write back and emit
    always_comb
    begin
        state_next     = state_reg;
        known_next     = known_reg;
        go             = 1'b0;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !barrier_ch.ready;

        unique case (state_reg)
            rbt_pkg::BACK_READ:
            begin
                if (head_valid)
                begin
                    state_next = rbt_pkg::BACK_EXEC;
                end
            end
            rbt_pkg::BACK_EXEC:
            begin
                if (!want_emit || out_free)
                begin
                    go         = 1'b1;
                    state_next = rbt_pkg::BACK_READ;
                    if (head_item.cmd == rbt_pkg::CMD_CLEAR)
                    begin
                        known_next = '0;
                    end
                    else if (want_write)
                    begin
                        known_next[idx] = 1'b1;
                    end
                    if (want_emit)
                    begin
                        res_next       = res_cand;
                        out_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = rbt_pkg::BACK_READ;
            end
        endcase
    end

    assign pop = go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbt_pkg::BACK_READ;
            known_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            known_reg     <= known_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (go && want_write)
        begin
            state_mem[idx] <= wr_entry;
        end
        rd_data_reg <= state_mem[idx];
    end

    assign barrier_ch.valid           = out_valid_reg;
    assign barrier_ch.resource_id_res = res_reg.resource_id_res;
    assign barrier_ch.barrier_kind    = res_reg.barrier_kind;
    assign barrier_ch.first_use       = res_reg.first_use;
    assign barrier_ch.src_stages      = res_reg.src_stages;
    assign barrier_ch.src_access      = res_reg.src_access;
    assign barrier_ch.dst_stages      = res_reg.dst_stages;
    assign barrier_ch.dst_access      = res_reg.dst_access;
    assign barrier_ch.old_layout      = res_reg.old_layout;
    assign barrier_ch.new_layout      = res_reg.new_layout;
    assign barrier_ch.aspect_mask     = res_reg.aspect_mask;
    assign barrier_ch.level_count     = res_reg.level_count;
    assign barrier_ch.layer_count     = res_reg.layer_count;

    `RBT_ASSERT_NEXT(a_clear_empties, state_reg == rbt_pkg::BACK_EXEC && head_item.cmd == rbt_pkg::CMD_CLEAR, known_reg == '0, "frame start left known bits set")
    `RBT_ASSERT_IMPLY(a_load_from_exec, $rose(out_valid_reg), $past(state_reg) == rbt_pkg::BACK_EXEC, "barrier appeared outside execute")
    `RBT_ASSERT_NEXT(a_exec_holds, state_reg == rbt_pkg::BACK_EXEC && want_emit && !out_free, state_reg == rbt_pkg::BACK_EXEC, "execute left while output blocked")

endmodule

### rtl/core/resource_barrier_tracker.sv
// Resource barrier tracker: an accepted item passes the queue, a registered read of
// the state table's single port, then decide and write back, and lands in the output
// register. The back end ends one item before it reads the next, and waits in
// execute while a barrier is due and the output still holds an untaken one. Items with
// no effect are taken by the front and never queued. Reset clears the known bits, the
// queue and the output valid bit at once; the state table itself is not cleared and needs no clearing pass.
module resource_barrier_tracker (
    input  logic          clk,
    input  logic          rst_n,
    rbt_use_if.sink       use_ch,
    rbt_barrier_if.source barrier_ch
);

    // Front to queue
    logic             q_push;
    logic             q_ready;
    rbt_pkg::q_item_t q_item;

    // Queue to back
    logic             head_valid;
    logic             pop;
    rbt_pkg::q_item_t head_item;

    // Classify each item; drop the ones that neither change state nor emit
    rbt_front u_front (
        .use_ch (use_ch),
        .q_ready(q_ready),
        .q_push (q_push),
        .q_item (q_item)
    );

    // Decouple acceptance from the table's read-modify-write
    rbt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .ready     (q_ready),
        .pop       (pop),
        .head_valid(head_valid),
        .head_item (head_item)
    );

    // Hold the table, decide on barriers and hold the result until taken
    rbt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_item (head_item),
        .pop       (pop),
        .barrier_ch(barrier_ch)
    );

endmodule

### verif/tb_resource_barrier_tracker.sv
// Self-checking bench for the resource barrier tracker: it drives image and buffer uses, present
// requests, frame starts and malformed items, and checks every barrier against a predictor built from scratch.
// Depends on rbt_pkg and the channel interfaces in rbt_channels.sv.
`timescale 1ns / 1ps

module tb_resource_barrier_tracker;

    import rbt_pkg::*;

    // Codes that the package leaves unnamed but the input fields can still carry
    localparam logic [1:0] OP_NOP    = 2'd3;
    localparam logic [1:0] PK_OTHER  = 2'd2;
    localparam logic [1:0] PK_SPARE  = 2'd3;
    localparam logic [1:0] FK_COLOR  = 2'd0;
    localparam logic [1:0] FK_SPARE  = 2'd3;
    localparam logic [2:0] USG_OTHER = 3'd6;
    localparam logic [2:0] USG_SPARE = 3'd7;

    localparam int RANDOM_ITEMS = 1520;
    localparam int POOL_SIZE    = 16;
    localparam int HOLD_EVERY   = 350;
    localparam int QUIET_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int SHOWN_FAULTS = 10;

    // One command as the sender holds it; hold_first makes the sender wait for every
    // outstanding barrier before it offers this item
    typedef struct {
        logic [1:0]         op;
        logic [ID_W-1:0]    id;
        logic               img;
        logic               swc;
        logic [2:0]         usage;
        logic               rd;
        logic               wr;
        logic [1:0]         pk;
        logic [1:0]         fk;
        logic [LEVEL_W-1:0] mips;
        logic [LAYER_W-1:0] layers;
        bit                 hold_first;
    } use_item_t;

    logic clk = 1'b0;
    logic rst_n;

    rbt_use_if     use_ch ();
    rbt_barrier_if barrier_ch ();

    resource_barrier_tracker i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .use_ch     (use_ch),
        .barrier_ch (barrier_ch)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    use_item_t   cmd_q [$];       // commands not yet offered to the block
    res_t        barrier_due [$]; // barriers predicted but not yet seen
    use_item_t   pool [POOL_SIZE];

    // Predictor's own copy of the per-resource table
    bit                  track_known  [NUM_RESOURCES];
    logic [MASK_W-1:0]   track_stages [NUM_RESOURCES];
    logic [MASK_W-1:0]   track_access [NUM_RESOURCES];
    logic [LAYOUT_W-1:0] track_layout [NUM_RESOURCES];

    int unsigned fault_cnt     = 0;
    int unsigned barriers_seen = 0;
    int unsigned quiet_cycles  = 0;
    logic        settled;

    int unsigned send_gap   = 0;
    bit          send_burst = 1'b0;
    int unsigned take_stall = 0;
    bit          take_burst = 1'b0;

    // Stages that a shader use runs in for a given pass kind
    function automatic logic [MASK_W-1:0] shader_stage(input logic [1:0] pk);
        case (pk)
            PK_COMPUTE:  return STG_COMPUTE;
            PK_GRAPHICS: return STG_ALL_GFX;
            default:     return STG_ALL_CMD;
        endcase
    endfunction

    // Advance the table by one command; return 1 with the barrier it causes, if any
    function automatic bit predict_barrier(input use_item_t u, output res_t br);
        logic [MASK_W-1:0]   need_stg;
        logic [MASK_W-1:0]   need_acc;
        logic [LAYOUT_W-1:0] need_lay;
        logic [MASK_W-1:0]   prev_stg;
        logic [MASK_W-1:0]   prev_acc;
        logic [LAYOUT_W-1:0] prev_lay;
        bit                  fresh;
        bit                  any_write;
        br       = '0;
        need_stg = STG_NONE;
        need_acc = ACC_NONE;
        need_lay = LAY_UNDEF;
        if (u.op == OP_FRAME)
        begin
            foreach (track_known[i])
                track_known[i] = 1'b0;
            return 1'b0;
        end
        if (u.op == OP_PRESENT)
        begin
            if (!u.swc || !track_known[u.id] || track_layout[u.id] == LAY_PRESENT)
                return 1'b0;
            br.resource_id_res = u.id;
            br.barrier_kind    = BK_PRESENT_POST;
            br.first_use       = 1'b0;
            br.src_stages      = track_stages[u.id];
            br.src_access      = track_access[u.id];
            br.dst_stages      = STG_NONE;
            br.dst_access      = ACC_NONE;
            br.old_layout      = track_layout[u.id];
            br.new_layout      = LAY_PRESENT;
            br.aspect_mask     = ASP_COLOR;
            br.level_count     = LEVEL_W'(1);
            br.layer_count     = LAYER_W'(1);
            track_stages[u.id] = STG_NONE;
            track_access[u.id] = ACC_NONE;
            track_layout[u.id] = LAY_PRESENT;
            return 1'b1;
        end
        if (u.op != OP_USE)
            return 1'b0;

        // Map the use to the stages, access and layout it needs
        if (u.img)
        begin
            case (u.usage)
                USG_COLOR, USG_RESOLVE:
                begin
                    need_stg = STG_COLOR_OUT;
                    need_acc = (u.rd ? ACC_COLOR_RD : ACC_NONE) |
                               (u.wr ? ACC_COLOR_WR : ACC_NONE);
                    need_lay = LAY_COLOR;
                end
                USG_DS:
                begin
                    need_stg = STG_EARLY_FT | STG_LATE_FT;
                    need_acc = (u.rd ? ACC_DS_RD : ACC_NONE) | (u.wr ? ACC_DS_WR : ACC_NONE);
                    need_lay = u.wr ? LAY_DS : LAY_DS_RO;
                end
                USG_COPY:
                begin
                    need_stg = STG_TRANSFER;
                    need_acc = (u.rd ? ACC_XFER_RD : ACC_NONE) |
                               (u.wr ? ACC_XFER_WR : ACC_NONE);
                    need_lay = (u.rd && u.wr) ? LAY_GENERAL :
                               (u.rd ? LAY_XFER_SRC : LAY_XFER_DST);
                end
                USG_SHADER:
                begin
                    need_stg = shader_stage(u.pk);
                    need_acc = (u.rd ? ACC_SHADER_RD : ACC_NONE) |
                               (u.wr ? ACC_SHADER_WR : ACC_NONE);
                    need_lay = u.wr ? LAY_GENERAL : LAY_SHADER_RO;
                end
                USG_SUBPASS:
                begin
                    need_stg = STG_FRAG;
                    need_acc = ACC_INPUT_RD;
                    need_lay = LAY_SHADER_RO;
                end
                default:
                    return 1'b0;
            endcase
        end
        else if (u.usage == USG_COPY)
        begin
            need_stg = STG_TRANSFER;
            need_acc = (u.rd ? ACC_XFER_RD : ACC_NONE) | (u.wr ? ACC_XFER_WR : ACC_NONE);
        end
        else if (u.usage == USG_SHADER)
        begin
            need_stg = shader_stage(u.pk);
            need_acc = (u.rd ? ACC_SHADER_RD : ACC_NONE) | (u.wr ? ACC_SHADER_WR : ACC_NONE);
        end
        else
            return 1'b0;

        // Previous state: the table when known, otherwise the first-use defaults
        fresh = !track_known[u.id];
        if (!fresh)
        begin
            prev_stg = track_stages[u.id];
            prev_acc = track_access[u.id];
            prev_lay = track_layout[u.id];
        end
        else if (u.img && u.swc)
        begin
            prev_stg = STG_NONE;
            prev_acc = ACC_NONE;
            prev_lay = LAY_PRESENT;
        end
        else
        begin
            prev_stg = STG_ALL_CMD;
            prev_acc = ACC_MEM_RD | ACC_MEM_WR;
            prev_lay = LAY_UNDEF;
        end

        track_known[u.id]  = 1'b1;
        track_stages[u.id] = need_stg;
        track_access[u.id] = need_acc;
        track_layout[u.id] = need_lay;

        any_write = ((prev_acc & ACC_ANY_WRITE) != '0) || ((need_acc & ACC_ANY_WRITE) != '0);
        br.resource_id_res = u.id;
        br.src_stages      = prev_stg;
        br.src_access      = prev_acc;
        br.dst_stages      = need_stg;
        br.dst_access      = need_acc;
        if (u.img)
        begin
            if (prev_lay == need_lay && !any_write)
                return 1'b0;
            br.barrier_kind = BK_IMAGE_PRE;
            br.first_use    = fresh;
            br.old_layout   = prev_lay;
            br.new_layout   = need_lay;
            br.aspect_mask  = (u.fk == FK_DS) ? ASP_DEPTH_S :
                              ((u.fk == FK_DEPTH) ? ASP_DEPTH : ASP_COLOR);
            br.level_count  = u.mips;
            br.layer_count  = u.layers;
            return 1'b1;
        end
        if (!any_write)
            return 1'b0;
        br.barrier_kind = BK_BUFFER_PRE;
        br.first_use    = 1'b0;
        br.old_layout   = LAY_UNDEF;
        br.new_layout   = LAY_UNDEF;
        br.aspect_mask  = ASP_COLOR;
        br.level_count  = LEVEL_W'(1);
        br.layer_count  = LAYER_W'(1);
        return 1'b1;
    endfunction

    // Count a field mismatch; show only the first few
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fault_cnt++;
            if (fault_cnt <= SHOWN_FAULTS)
                $display("barrier %0d: %s expected %0h got %0h", barriers_seen, name,
                         want, got);
        end
    endtask

    task automatic push_cmd(input logic [1:0] op, input logic [ID_W-1:0] id,
                            input logic img, input logic swc, input logic [2:0] usage,
                            input logic rd, input logic wr, input logic [1:0] pk,
                            input logic [1:0] fk, input logic [LEVEL_W-1:0] mips,
                            input logic [LAYER_W-1:0] layers);
        use_item_t c;
        c = '{op, id, img, swc, usage, rd, wr, pk, fk, mips, layers, 1'b0};
        cmd_q.push_back(c);
    endtask

    // Draw a fresh set of resources for a frame; most images, a few swapchain images,
    // mostly small extents with the odd extreme one
    function automatic void refresh_pool();
        foreach (pool[p])
        begin
            pool[p].id     = $urandom_range(0, NUM_RESOURCES - 1);
            pool[p].img    = $urandom_range(0, 9) < 7;
            pool[p].swc    = pool[p].img ? ($urandom_range(0, 2) == 0) : $urandom_range(0, 1);
            pool[p].fk     = $urandom_range(0, 3);
            pool[p].mips   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) :
                                                           $urandom_range(1, 16);
            pool[p].layers = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) :
                                                           $urandom_range(1, 8);
        end
    endfunction

    // Sender: offer the next command once the gap drawn after the last acceptance has run
    // out. Hold the item on the wire until it is taken; a single assignment to valid per
    // edge keeps a back-to-back item high.
    always @(posedge clk or negedge rst_n)
    begin : sender
        use_item_t nxt;
        bit        hold;
        if (!rst_n)
        begin
            use_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else if (!use_ch.valid || use_ch.ready)
        begin
            if (use_ch.valid)
            begin
                // the item on the wire is taken at this edge: draw the gap before the next
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 3);
            end
            // a hold_first item waits until the wire is empty and nothing is owed
            hold = cmd_q.size() == 0 || send_gap != 0 ||
                   (cmd_q[0].hold_first && (use_ch.valid || !settled));
            if (send_gap != 0)
                send_gap--;
            if (hold)
                use_ch.valid <= 1'b0;
            else
            begin
                nxt = cmd_q.pop_front();
                use_ch.valid        <= 1'b1;
                use_ch.op           <= nxt.op;
                use_ch.resource_id  <= nxt.id;
                use_ch.is_image     <= nxt.img;
                use_ch.is_swapchain <= nxt.swc;
                use_ch.usage        <= nxt.usage;
                use_ch.reads        <= nxt.rd;
                use_ch.writes       <= nxt.wr;
                use_ch.pass_kind    <= nxt.pk;
                use_ch.format_kind  <= nxt.fk;
                use_ch.mip_levels   <= nxt.mips;
                use_ch.array_layers <= nxt.layers;
            end
        end
    end

    // Receiver: after each barrier is taken, drop ready for a drawn number of cycles;
    // burst stretches keep it high throughout
    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            barrier_ch.ready <= 1'b0;
            take_stall = 0;
        end
        else
        begin
            if (barrier_ch.valid && barrier_ch.ready)
            begin
                if ($urandom_range(0, 39) == 0)
                    take_burst = !take_burst;
                take_stall = take_burst ? 0 : $urandom_range(0, 3);
            end
            if (take_stall != 0)
            begin
                take_stall--;
                barrier_ch.ready <= 1'b0;
            end
            else
                barrier_ch.ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted command, then check any accepted barrier against
    // the oldest prediction. Doing both in one block fixes their order within an edge.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        use_item_t seen;
        res_t      want;
        res_t      got;
        if (!rst_n)
        begin
            settled <= 1'b1;
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (use_ch.valid && use_ch.ready)
            begin
                quiet_cycles    = 0;
                seen.op         = use_ch.op;
                seen.id         = use_ch.resource_id;
                seen.img        = use_ch.is_image;
                seen.swc        = use_ch.is_swapchain;
                seen.usage      = use_ch.usage;
                seen.rd         = use_ch.reads;
                seen.wr         = use_ch.writes;
                seen.pk         = use_ch.pass_kind;
                seen.fk         = use_ch.format_kind;
                seen.mips       = use_ch.mip_levels;
                seen.layers     = use_ch.array_layers;
                seen.hold_first = 1'b0;
                if (predict_barrier(seen, want))
                    barrier_due.push_back(want);
            end
            if (barrier_ch.valid && barrier_ch.ready)
            begin
                quiet_cycles        = 0;
                got.resource_id_res = barrier_ch.resource_id_res;
                got.barrier_kind    = barrier_ch.barrier_kind;
                got.first_use       = barrier_ch.first_use;
                got.src_stages      = barrier_ch.src_stages;
                got.src_access      = barrier_ch.src_access;
                got.dst_stages      = barrier_ch.dst_stages;
                got.dst_access      = barrier_ch.dst_access;
                got.old_layout      = barrier_ch.old_layout;
                got.new_layout      = barrier_ch.new_layout;
                got.aspect_mask     = barrier_ch.aspect_mask;
                got.level_count     = barrier_ch.level_count;
                got.layer_count     = barrier_ch.layer_count;
                if (barrier_due.size() == 0)
                begin
                    fault_cnt++;
                    if (fault_cnt <= SHOWN_FAULTS)
                        $display("barrier %0d: none expected, got one for resource %0d",
                                 barriers_seen, got.resource_id_res);
                end
                else
                begin
                    want = barrier_due.pop_front();
                    check_field("resource_id_res", want.resource_id_res, got.resource_id_res);
                    check_field("barrier_kind", want.barrier_kind, got.barrier_kind);
                    check_field("first_use", want.first_use, got.first_use);
                    check_field("src_stages", want.src_stages, got.src_stages);
                    check_field("src_access", want.src_access, got.src_access);
                    check_field("dst_stages", want.dst_stages, got.dst_stages);
                    check_field("dst_access", want.dst_access, got.dst_access);
                    check_field("old_layout", want.old_layout, got.old_layout);
                    check_field("new_layout", want.new_layout, got.new_layout);
                    check_field("aspect_mask", want.aspect_mask, got.aspect_mask);
                    check_field("level_count", want.level_count, got.level_count);
                    check_field("layer_count", want.layer_count, got.layer_count);
                end
                barriers_seen++;
            end
            // registered so that the sender reads a value settled at the previous edge
            settled <= (barrier_due.size() == 0);
        end
    end

    // Watchdog: end the run when neither channel has moved for too long
    initial
    begin : watchdog
        do
            @(negedge clk);
        while (quiet_cycles < QUIET_LIMIT);
        $display("tb_resource_barrier_tracker: errors");
        $finish;
    end

    initial
    begin : stimulus
        use_item_t cmd;
        int unsigned roll;
        int unsigned p;

        // Hold every input at a known value until the sender takes over
        rst_n                   = 1'b0;
        use_ch.valid            = 1'b0;
        use_ch.op               = OP_USE;
        use_ch.resource_id      = '0;
        use_ch.is_image         = 1'b0;
        use_ch.is_swapchain     = 1'b0;
        use_ch.usage            = USG_COLOR;
        use_ch.reads            = 1'b0;
        use_ch.writes           = 1'b0;
        use_ch.pass_kind        = PK_COMPUTE;
        use_ch.format_kind      = FK_COLOR;
        use_ch.mip_levels       = '0;
        use_ch.array_layers     = '0;
        barrier_ch.ready        = 1'b0;

        // Directed part: first uses, defaults, every usage and the corner cases
        push_cmd(OP_FRAME,   0,   0, 0, USG_COLOR,   0, 0, PK_COMPUTE,  FK_COLOR, 0, 0);
        // plain image: first use, then a read after a write, then a read after a read
        push_cmd(OP_USE,     0,   1, 0, USG_COLOR,   1, 1, PK_GRAPHICS, FK_COLOR, 1, 1);
        push_cmd(OP_USE,     0,   1, 0, USG_RESOLVE, 1, 0, PK_GRAPHICS, FK_COLOR, 1, 1);
        push_cmd(OP_USE,     0,   1, 0, USG_COLOR,   1, 0, PK_GRAPHICS, FK_COLOR, 1, 1);
        // swapchain image starting from present, odd format kind, widest extents
        push_cmd(OP_USE,     255, 1, 1, USG_COLOR,   0, 1, PK_GRAPHICS, FK_SPARE, 31, 4095);
        push_cmd(OP_PRESENT, 255, 1, 1, USG_COLOR,   0, 0, PK_COMPUTE,  FK_COLOR, 0, 0);
        // already presented, never seen, and not a swapchain request
        push_cmd(OP_PRESENT, 255, 1, 1, USG_COLOR,   0, 0, PK_COMPUTE,  FK_COLOR, 0, 0);
        push_cmd(OP_PRESENT, 7,   1, 1, USG_COLOR,   0, 0, PK_COMPUTE,  FK_COLOR, 0, 0);
        push_cmd(OP_PRESENT, 0,   1, 0, USG_COLOR,   0, 0, PK_COMPUTE,  FK_COLOR, 0, 0);
        // depth: write then read-only, zero extents then 16 levels and 2048 layers
        push_cmd(OP_USE,     1,   1, 0, USG_DS,      0, 1, PK_GRAPHICS, FK_DS,    0, 0);
        push_cmd(OP_USE,     1,   1, 0, USG_DS,      1, 0, PK_GRAPHICS, FK_DEPTH, 16, 2048);
        // copies: neither flag, read only, read and write
        push_cmd(OP_USE,     2,   1, 0, USG_COPY,    0, 0, PK_SPARE,    FK_COLOR, 2, 3);
        push_cmd(OP_USE,     2,   1, 0, USG_COPY,    1, 0, PK_OTHER,    FK_COLOR, 2, 3);
        push_cmd(OP_USE,     2,   1, 0, USG_COPY,    1, 1, PK_COMPUTE,  FK_COLOR, 2, 3);
        // shader uses in compute, graphics and another pass kind, then a subpass input
        push_cmd(OP_USE,     3,   1, 0, USG_SHADER,  0, 1, PK_COMPUTE,  FK_COLOR, 4, 6);
        push_cmd(OP_USE,     3,   1, 0, USG_SHADER,  1, 0, PK_GRAPHICS, FK_COLOR, 4, 6);
        push_cmd(OP_USE,     3,   1, 0, USG_SHADER,  1, 0, PK_OTHER,    FK_COLOR, 4, 6);
        push_cmd(OP_USE,     4,   1, 0, USG_SUBPASS, 1, 0, PK_GRAPHICS, FK_COLOR, 1, 1);
        // unmapped image usages leave the table alone
        push_cmd(OP_USE,     5,   1, 0, USG_OTHER,   1, 1, PK_GRAPHICS, FK_COLOR, 1, 1);
        push_cmd(OP_USE,     5,   1, 0, USG_SPARE,   1, 1, PK_GRAPHICS, FK_COLOR, 1, 1);
        // buffer: write, read after write, read after read, unmapped usage
        push_cmd(OP_USE,     10,  0, 0, USG_COPY,    0, 1, PK_COMPUTE,  FK_COLOR, 1, 1);
        push_cmd(OP_USE,     10,  0, 0, USG_SHADER,  1, 0, PK_SPARE,    FK_COLOR, 1, 1);
        push_cmd(OP_USE,     10,  0, 0, USG_SHADER,  1, 0, PK_COMPUTE,  FK_COLOR, 1, 1);
        push_cmd(OP_USE,     10,  0, 0, USG_COLOR,   0, 1, PK_COMPUTE,  FK_COLOR, 1, 1);
        // unknown op, then a frame start makes resource 0 new again
        push_cmd(OP_NOP,     0,   1, 0, USG_COLOR,   1, 1, PK_COMPUTE,  FK_COLOR, 1, 1);
        push_cmd(OP_FRAME,   0,   0, 0, USG_COLOR,   0, 0, PK_COMPUTE,  FK_COLOR, 0, 0);
        push_cmd(OP_USE,     0,   1, 0, USG_COLOR,   1, 0, PK_GRAPHICS, FK_COLOR, 1, 1);

        // Random part: mostly well-formed uses of a small pool so that entries are hit
        // again and again, with presents, frame starts and some noise mixed in
        refresh_pool();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll  = $urandom_range(0, 99);
            p     = $urandom_range(0, POOL_SIZE - 1);
            cmd   = pool[p];
            cmd.op    = OP_USE;
            cmd.usage = USG_COLOR;
            cmd.rd    = $urandom_range(0, 1);
            cmd.wr    = $urandom_range(0, 1);
            cmd.pk    = ($urandom_range(0, 9) == 0) ? PK_SPARE : $urandom_range(0, 2);
            cmd.hold_first = (n % HOLD_EVERY) == HOLD_EVERY / 2;
            if (roll < 2)
            begin
                cmd.op = OP_FRAME;
                refresh_pool();
            end
            else if (roll < 3)
                cmd.op = OP_NOP;
            else if (roll < 13)
                cmd.op = OP_PRESENT;
            else if (roll < 88)
            begin
                if (cmd.img)
                    cmd.usage = $urandom_range(USG_COLOR, USG_SUBPASS);
                else
                    cmd.usage = $urandom_range(0, 1) ? USG_COPY : USG_SHADER;
            end
            else
            begin
                // noise: any value that the fields can hold
                cmd.id     = $urandom;
                cmd.img    = $urandom;
                cmd.swc    = $urandom;
                cmd.usage  = $urandom;
                cmd.pk     = $urandom;
                cmd.fk     = $urandom;
                cmd.mips   = $urandom;
                cmd.layers = $urandom;
            end
            cmd_q.push_back(cmd);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every command to be taken and every barrier to come back, then let
        // the block settle in case it emits something it should not
        while (cmd_q.size() != 0 || use_ch.valid)
            @(negedge clk);
        while (barrier_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fault_cnt == 0 && barrier_due.size() == 0)
            $display("tb_resource_barrier_tracker: clean");
        else
            $display("tb_resource_barrier_tracker: errors");
        $finish;
    end

endmodule
